// File: rtl/slcr_pkg.sv
// Shared types and constants for the sorted list common removal unit.
// No dependencies; every other file in rtl imports this package.
package slcr_pkg;

  localparam int unsigned DEFAULT_LIST_DEPTH = 32;
  localparam int unsigned VALUE_W = 32;

  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_APPEND_C = 2'd2,
    OP_FINISH   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      last;
    logic                      empty_res;
    logic                      overflow;
  } out_t;

  // One A element as it sits in the sorted chain, with its B and C hit marks.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      hit_b;
    logic                      hit_c;
  } a_entry_t;

  // Broadcast control from the top level to every sort cell.
  typedef struct packed {
    logic                      insert;
    logic                      shift;
    logic                      mark_b;
    logic                      mark_c;
    logic signed [VALUE_W-1:0] probe;
    logic                      probe_hit_b;
    logic                      probe_hit_c;
  } sort_ctl_t;

endpackage

// File: rtl/slcr_match_cell.sv
// One entry of the B or C store with its own equality comparator.
// Depends on slcr_pkg.
module slcr_match_cell
  import slcr_pkg::*;
(
  input  logic                      clk,
  input  logic                      we,
  input  logic                      valid,
  input  logic signed [VALUE_W-1:0] probe,
  output logic                      hit
);

  logic signed [VALUE_W-1:0] value;

  always_ff @(posedge clk) begin
    if (we) begin
      value <= probe;
    end
  end

  assign hit = valid && (value == probe);

endmodule

// File: rtl/slcr_sort_cell.sv
// One cell of the sorted A chain: insertion by shifting right, draining by
// shifting left, and marking of B and C hits. Depends on slcr_pkg.
module slcr_sort_cell
  import slcr_pkg::*;
(
  input  logic      clk,
  input  sort_ctl_t ctl,
  input  logic      valid,
  input  logic      left_valid,
  input  logic      left_gt,
  input  a_entry_t  left_data,
  input  a_entry_t  right_data,
  output a_entry_t  data,
  output logic      gt,
  output logic      keep
);

  logic eq;
  logic take;

  assign gt   = valid && (data.value > ctl.probe);
  assign eq   = valid && (data.value == ctl.probe);
  // The chain is sorted, so the cells that hold larger values form a tail;
  // they move one place right and the first free cell takes the overflow.
  assign take = ctl.insert && (gt || (!valid && left_valid));
  assign keep = valid && !(data.hit_b && data.hit_c);

  always_ff @(posedge clk) begin
    if (take) begin
      if (left_gt) begin
        data <= left_data;
      end else begin
        data <= '{value: ctl.probe, hit_b: ctl.probe_hit_b, hit_c: ctl.probe_hit_c};
      end
    end else if (ctl.shift) begin
      data <= right_data;
    end else begin
      if (ctl.mark_b && eq) begin
        data.hit_b <= 1'b1;
      end
      if (ctl.mark_c && eq) begin
        data.hit_c <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/sorted_list_common_removal_unit.sv
// Top level of the sorted list common removal unit: control, counts, output
// register and the rows of sort and match cells. Depends on slcr_pkg,
// slcr_sort_cell and slcr_match_cell.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready | in_data  (in_t)
//   out     | output    | out_valid/out_ready | out_data (out_t)
//
// Appends are accepted back to back while idle.
// A finish drains the A chain by shifting the sort chain left, up to the last
// A element kept, or emits one empty result when nothing remains; while the
// output stalls, a kept element waits at the head. No input is taken during a run.
// Reset clears the counts, the overflow flag, the state and the output valid.
module sorted_list_common_removal_unit
  import slcr_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = DEFAULT_LIST_DEPTH
)(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  state_t            state;
  logic [CW-1:0]     count_a;
  logic [CW-1:0]     count_b;
  logic [CW-1:0]     count_c;
  logic              dropped;
  logic              ovf_run;
  logic              empty_run;

  logic              accept;
  logic              full_a, full_b, full_c;
  logic              slot_free;
  logic              step;
  logic              load;
  logic              run_done;
  logic              keep_rest;
  sort_ctl_t         ctl;

  a_entry_t               a_data [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]  a_valid;
  logic [LIST_DEPTH-1:0]  a_gt;
  logic [LIST_DEPTH-1:0]  keep_vec;
  logic [LIST_DEPTH-1:0]  hit_b_vec;
  logic [LIST_DEPTH-1:0]  hit_c_vec;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign full_a    = (count_a == CW'(LIST_DEPTH));
  assign full_b    = (count_b == CW'(LIST_DEPTH));
  assign full_c    = (count_c == CW'(LIST_DEPTH));
  assign slot_free = !out_valid || out_ready;
  assign keep_rest = |(keep_vec >> 1);

  // Removed elements at the head are skipped even while the output stalls.
  assign step     = (state == ST_EMIT) && !empty_run && (slot_free || !keep_vec[0]);
  assign load     = (state == ST_EMIT) && slot_free && (empty_run || keep_vec[0]);
  assign run_done = load && (empty_run || !keep_rest);

  always_comb begin
    ctl.insert      = accept && (in_data.operation == OP_APPEND_A) && !full_a;
    ctl.mark_b      = accept && (in_data.operation == OP_APPEND_B) && !full_b;
    ctl.mark_c      = accept && (in_data.operation == OP_APPEND_C) && !full_c;
    ctl.shift       = step;
    ctl.probe       = in_data.value;
    ctl.probe_hit_b = |hit_b_vec;
    ctl.probe_hit_c = |hit_c_vec;
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_row
    a_entry_t left_d;
    a_entry_t right_d;
    logic     left_v;
    logic     left_g;

    assign a_valid[i] = (CW'(i) < count_a);

    if (i == 0) begin : g_head
      assign left_d = '0;
      assign left_v = 1'b1;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_d = a_data[i-1];
      assign left_v = a_valid[i-1];
      assign left_g = a_gt[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid
      assign right_d = a_data[i+1];
    end

    slcr_sort_cell u_sort (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (a_valid[i]),
      .left_valid (left_v),
      .left_gt    (left_g),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (a_data[i]),
      .gt         (a_gt[i]),
      .keep       (keep_vec[i])
    );

    slcr_match_cell u_match_b (
      .clk   (clk),
      .we    (ctl.mark_b && (count_b == CW'(i))),
      .valid (CW'(i) < count_b),
      .probe (in_data.value),
      .hit   (hit_b_vec[i])
    );

    slcr_match_cell u_match_c (
      .clk   (clk),
      .we    (ctl.mark_c && (count_c == CW'(i))),
      .valid (CW'(i) < count_c),
      .probe (in_data.value),
      .hit   (hit_c_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count_a <= '0;
      count_b <= '0;
      count_c <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data.operation)
              OP_APPEND_A: begin
                if (full_a) dropped <= 1'b1;
                else        count_a <= count_a + CW'(1);
              end
              OP_APPEND_B: begin
                if (full_b) dropped <= 1'b1;
                else        count_b <= count_b + CW'(1);
              end
              OP_APPEND_C: begin
                if (full_c) dropped <= 1'b1;
                else        count_c <= count_c + CW'(1);
              end
              OP_FINISH: begin
                // The hit marks already live in the A chain, so B and C
                // can be emptied as the run starts.
                count_b <= '0;
                count_c <= '0;
                dropped <= 1'b0;
                state   <= ST_EMIT;
              end
              default: ;
            endcase
          end
        end
        ST_EMIT: begin
          if (run_done) begin
            count_a <= '0;
            state   <= ST_IDLE;
          end else if (step) begin
            count_a <= count_a - CW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Run-wide payload captured at the finish transfer.
  always_ff @(posedge clk) begin
    if (accept && (in_data.operation == OP_FINISH)) begin
      ovf_run   <= dropped;
      empty_run <= !(|keep_vec);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.value_res <= empty_run ? '0 : a_data[0].value;
      out_data.last      <= empty_run || !keep_rest;
      out_data.empty_res <= empty_run;
      out_data.overflow  <= ovf_run;
    end
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.empty_res) |-> out_data.last)
    else $error("empty result not marked last");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CW'(LIST_DEPTH)) && (count_b <= CW'(LIST_DEPTH))
    && (count_c <= CW'(LIST_DEPTH)))
    else $error("store count beyond depth");

  a_mid_run_emitting: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> (state == ST_EMIT))
    else $error("run left before its final result");

  a_emit_drains: assert property (@(posedge clk) disable iff (rst)
    (step && !run_done) |=> (count_a == $past(count_a) - CW'(1)))
    else $error("chain shift did not consume one element");

endmodule
